// ===== hw/rtl/knn2c_pkg.sv =====
// Shared types, sizes and codes for the two-class nearest-neighbour classifier.
// No dependencies; used by every module of the block.
`default_nettype none
package knn2c_pkg;

	localparam int MAX_POINTS = 64;
	localparam int MAX_K      = 16;
	localparam int COORD_BITS = 16;

	// Fixed field widths
	localparam int FUNC_W  = 2;
	localparam int PORT_W  = 16;
	localparam int GRP_W   = 2;
	localparam int NB_W    = 5;
	localparam int VOTE_W  = 5;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;

	// Derived sizes
	localparam int PTR_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W   = $clog2(MAX_POINTS + 1);
	localparam int K_W     = $clog2(MAX_K + 1);
	localparam int KIDX_W  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int DIFF_W  = COORD_BITS + 1;
	localparam int SQ_W    = 2 * COORD_BITS + 1;
	localparam int DIST_W  = SQ_W + 2;

	// Function codes
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

	// Group labels that vote
	localparam logic [GRP_W-1:0] GRP_ZERO = 2'd0;
	localparam logic [GRP_W-1:0] GRP_ONE  = 2'd1;

	// Register word index
	localparam logic [ADDR_W-3:0] REG_NEIGHBOURS = '0;
	localparam logic [NB_W-1:0]   NEIGHBOURS_RST = 5'd3;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t            x;
		coord_t            y;
		coord_t            z;
		logic [GRP_W-1:0]  grp;
	} point_t;

	typedef struct packed {
		logic              vld;
		logic [DIST_W-1:0] range_sq;
		logic [PTR_W-1:0]  idx;
		logic [GRP_W-1:0]  grp;
	} cand_t;

	// Sign-extend the port word, then keep the low COORD_BITS bits.
	function automatic coord_t coord_of(input logic [PORT_W-1:0] raw);
		logic signed [31:0] w;
		w = 32'(signed'(raw));
		return w[COORD_BITS-1:0];
	endfunction

	// k clipped to MAX_K and to the number of stored points.
	function automatic logic [K_W-1:0] clip_k(input logic [NB_W-1:0] nb,
			input logic [CNT_W-1:0] cnt);
		int kn;
		kn = int'(nb);
		if (kn > MAX_K)
			kn = MAX_K;
		if (kn > int'(cnt))
			kn = int'(cnt);
		return K_W'(kn);
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/knn2c_dist.sv =====
// Two-stage squared-distance unit: per-axis squares, then their sum.
// Depends on knn2c_pkg.
`default_nettype none
module knn2c_dist (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        pt_vld,
	input  wire logic [knn2c_pkg::PTR_W-1:0] pt_idx,
	input  wire knn2c_pkg::point_t           pt,
	input  wire knn2c_pkg::point_t           qry,
	output knn2c_pkg::cand_t                 cand
);
	import knn2c_pkg::*;

	logic signed [DIFF_W-1:0]   dx, dy, dz;
	logic signed [2*DIFF_W-1:0] px, py, pz;

	logic [SQ_W-1:0]   sqx_s2, sqy_s2, sqz_s2;
	logic [GRP_W-1:0]  grp_s2;
	logic [PTR_W-1:0]  idx_s2;
	logic              vld_s2;
	logic              vld_s3;
	logic [DIST_W-1:0] rng_s3;
	logic [PTR_W-1:0]  idx_s3;
	logic [GRP_W-1:0]  grp_s3;

	always_comb begin
		dx = DIFF_W'(pt.x) - DIFF_W'(qry.x);
		dy = DIFF_W'(pt.y) - DIFF_W'(qry.y);
		dz = DIFF_W'(pt.z) - DIFF_W'(qry.z);
		px = dx * dx;
		py = dy * dy;
		pz = dz * dz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= pt_vld;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s2 <= px[SQ_W-1:0];
		sqy_s2 <= py[SQ_W-1:0];
		sqz_s2 <= pz[SQ_W-1:0];
		grp_s2 <= pt.grp;
		idx_s2 <= pt_idx;
		rng_s3 <= DIST_W'(sqx_s2) + DIST_W'(sqy_s2) + DIST_W'(sqz_s2);
		idx_s3 <= idx_s2;
		grp_s3 <= grp_s2;
	end

	assign cand = {vld_s3, rng_s3, idx_s3, grp_s3};

endmodule
`default_nettype wire

// ===== hw/rtl/knn2c_cell.sv =====
// One cell of the insertion chain: keeps the nearest candidate seen so far
// and passes the other one on. Depends on knn2c_pkg.
`default_nettype none
module knn2c_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      clr,
	input  wire knn2c_pkg::cand_t          in_c,
	output knn2c_pkg::cand_t               out_c,
	output logic [knn2c_pkg::GRP_W-1:0]    held_grp
);
	import knn2c_pkg::*;

	logic              held_vld_q, out_vld_q;
	logic [DIST_W-1:0] held_rng_q, out_rng_q;
	logic [PTR_W-1:0]  held_idx_q, out_idx_q;
	logic [GRP_W-1:0]  held_grp_q, out_grp_q;
	logic              take;

	// Rank on distance, then on load order, so an equal distance keeps the earlier point.
	assign take = in_c.vld && (!held_vld_q ||
		({in_c.range_sq, in_c.idx} < {held_rng_q, held_idx_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else if (clr) begin
			held_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else if (take) begin
			held_vld_q <= 1'b1;
			out_vld_q  <= held_vld_q;
		end else begin
			out_vld_q  <= in_c.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			held_rng_q <= in_c.range_sq;
			held_idx_q <= in_c.idx;
			held_grp_q <= in_c.grp;
			out_rng_q  <= held_rng_q;
			out_idx_q  <= held_idx_q;
			out_grp_q  <= held_grp_q;
		end else begin
			out_rng_q  <= in_c.range_sq;
			out_idx_q  <= in_c.idx;
			out_grp_q  <= in_c.grp;
		end
	end

	assign out_c    = {out_vld_q, out_rng_q, out_idx_q, out_grp_q};
	assign held_grp = held_grp_q;

endmodule
`default_nettype wire

// ===== hw/rtl/knn_two_class_classifier_unit.sv =====
// Top level of the two-class nearest-neighbour classifier: point store,
// command control, APB register, distance unit and cell chain.
// Depends on knn2c_pkg, knn2c_dist and knn2c_cell.
`default_nettype none
// Clear and load commands complete in the cycle they are accepted and never
// raise busy. A classify command keeps busy high until its result is ready,
// or for a single cycle when the effective k is zero: the n stored points
// are read from the point store one entry a cycle into the distance unit,
// each distance then walks the chain of MAX_K cells, and the votes of the k
// nearest are counted one cell a cycle. The result is shown for one cycle
// with done high and must be taken then; it cannot be held off.
module knn_two_class_classifier_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [knn2c_pkg::FUNC_W-1:0] func,
	input  wire logic [knn2c_pkg::PORT_W-1:0] coord_x,
	input  wire logic [knn2c_pkg::PORT_W-1:0] coord_y,
	input  wire logic [knn2c_pkg::PORT_W-1:0] coord_z,
	input  wire logic [knn2c_pkg::GRP_W-1:0]  group,
	output logic                            done,
	output logic                            class_out,
	output logic [knn2c_pkg::VOTE_W-1:0]    votes_zero,
	output logic [knn2c_pkg::VOTE_W-1:0]    votes_one,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [knn2c_pkg::ADDR_W-1:0] paddr,
	input  wire logic [knn2c_pkg::DATA_W-1:0] pwdata,
	output logic [knn2c_pkg::DATA_W-1:0]    prdata,
	output logic                            pready
);
	import knn2c_pkg::*;

	localparam int DRAIN_LEN = MAX_K + 4;
	localparam int DRN_W     = $clog2(DRAIN_LEN + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_VOTE  = 3'd3;

	logic [2:0]       state_q;
	logic [NB_W-1:0]  neighbours_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [DRN_W-1:0] drain_q;
	logic [K_W-1:0]   k_q;
	logic [K_W-1:0]   vote_idx_q;
	logic [K_W-1:0]   v0_q, v1_q;
	logic             done_q;
	logic             class_q;
	logic [VOTE_W-1:0] vz_q, vo_q;

	point_t           store_mem [MAX_POINTS];
	point_t           rd_pt_s1;
	logic [PTR_W-1:0] rd_idx_s1;
	logic             rd_vld_s1;
	point_t           qry_q;
	point_t           in_pt;

	logic             accept;
	logic             cfg_wr;
	logic             rd_en;
	logic             cell_clr;
	logic [K_W-1:0]   k_start;
	logic [GRP_W-1:0] vote_grp;

	cand_t            chain    [MAX_K+1];
	logic [GRP_W-1:0] held_grp [MAX_K];

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite &&
		(paddr[ADDR_W-1:2] == REG_NEIGHBOURS);

	assign prdata = (paddr[ADDR_W-1:2] == REG_NEIGHBOURS) ?
		{{(DATA_W-NB_W){1'b0}}, neighbours_q} : '0;

	always_comb begin
		in_pt.x   = coord_of(coord_x);
		in_pt.y   = coord_of(coord_y);
		in_pt.z   = coord_of(coord_z);
		in_pt.grp = group;
	end

	assign k_start  = clip_k(neighbours_q, count_q);
	assign rd_en    = (state_q == ST_SCAN);
	assign cell_clr = accept && (func == FUNC_QUERY);
	assign vote_grp = held_grp[vote_idx_q[KIDX_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			neighbours_q <= NEIGHBOURS_RST;
		else if (cfg_wr)
			neighbours_q <= pwdata[NB_W-1:0];
	end

	// Point store: one write port for loads, one registered read for scans.
	always_ff @(posedge clk) begin
		if (accept && (func == FUNC_LOAD) && (count_q < CNT_W'(MAX_POINTS)))
			store_mem[count_q[PTR_W-1:0]] <= in_pt;
		if (rd_en) begin
			rd_pt_s1  <= store_mem[rd_idx_q[PTR_W-1:0]];
			rd_idx_s1 <= rd_idx_q[PTR_W-1:0];
		end
		if (cell_clr)
			qry_q <= in_pt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_vld_s1 <= 1'b0;
		else
			rd_vld_s1 <= rd_en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			rd_idx_q   <= '0;
			drain_q    <= '0;
			k_q        <= '0;
			vote_idx_q <= '0;
			v0_q       <= '0;
			v1_q       <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (func)
							FUNC_CLEAR: count_q <= '0;
							FUNC_LOAD: begin
								if (count_q < CNT_W'(MAX_POINTS))
									count_q <= count_q + 1'b1;
							end
							FUNC_QUERY: begin
								k_q        <= k_start;
								rd_idx_q   <= '0;
								vote_idx_q <= '0;
								v0_q       <= '0;
								v1_q       <= '0;
								// nothing to rank: go straight to the vote
								if (k_start == '0)
									state_q <= ST_VOTE;
								else
									state_q <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if (rd_idx_q == count_q - 1'b1) begin
						drain_q <= DRN_W'(DRAIN_LEN);
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// hold until the last distance has walked the whole chain
					drain_q <= drain_q - 1'b1;
					if (drain_q == DRN_W'(1))
						state_q <= ST_VOTE;
				end
				ST_VOTE: begin
					if (vote_idx_q == k_q) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						vote_idx_q <= vote_idx_q + 1'b1;
						if (vote_grp == GRP_ZERO)
							v0_q <= v0_q + 1'b1;
						else if (vote_grp == GRP_ONE)
							v1_q <= v1_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_VOTE) && (vote_idx_q == k_q)) begin
			class_q <= !(v0_q > v1_q);
			vz_q    <= VOTE_W'(v0_q);
			vo_q    <= VOTE_W'(v1_q);
		end
	end

	knn2c_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.pt_vld (rd_vld_s1),
		.pt_idx (rd_idx_s1),
		.pt     (rd_pt_s1),
		.qry    (qry_q),
		.cand   (chain[0])
	);

	for (genvar gi = 0; gi < MAX_K; gi++) begin : g_cell
		knn2c_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.clr      (cell_clr),
			.in_c     (chain[gi]),
			.out_c    (chain[gi+1]),
			.held_grp (held_grp[gi])
		);
	end

	assign done       = done_q;
	assign class_out  = class_q;
	assign votes_zero = vz_q;
	assign votes_one  = vo_q;

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for knn_two_class_classifier_unit: clear, load and classify words plus APB
// writes of the neighbour count, each result checked against a vote model or a table row.
// Depends on knn2c_pkg and the RTL of the block.
module tb_top;
	import knn2c_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
	localparam logic [GRP_W-1:0]  GRP_NONE = 2'd2;
	localparam logic [GRP_W-1:0]  GRP_ODD  = 2'd3;
	localparam logic [ADDR_W-1:0] NB_ADDR  = {REG_NEIGHBOURS, 2'b00};

	localparam int ITEM_TARGET    = 1700;
	localparam int QUIET_TAIL     = 200;
	localparam int SETTLE_CYCLES  = 110;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DIR_ROWS       = 22;

	typedef struct packed {
		logic              cls;
		logic [VOTE_W-1:0] zero;
		logic [VOTE_W-1:0] one;
	} tally_t;

	typedef struct packed {
		logic [FUNC_W-1:0] fn;
		logic [PORT_W-1:0] x;
		logic [PORT_W-1:0] y;
		logic [PORT_W-1:0] z;
		logic [GRP_W-1:0]  grp;
		logic              known;
		logic              cls;
		logic [VOTE_W-1:0] v0;
		logic [VOTE_W-1:0] v1;
	} stim_row_t;

	logic                clk     = 1'b0;
	logic                arst_n  = 1'b0;
	logic                start   = 1'b0;
	logic [FUNC_W-1:0]   func    = FUNC_CLEAR;
	logic [PORT_W-1:0]   coord_x = '0;
	logic [PORT_W-1:0]   coord_y = '0;
	logic [PORT_W-1:0]   coord_z = '0;
	logic [GRP_W-1:0]    group   = GRP_ZERO;
	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [ADDR_W-1:0]   paddr   = '0;
	logic [DATA_W-1:0]   pwdata  = '0;
	logic                busy;
	logic                done;
	logic                class_out;
	logic [VOTE_W-1:0]   votes_zero;
	logic [VOTE_W-1:0]   votes_one;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// Point store and register copy of the vote model
	coord_t            pts_x   [MAX_POINTS];
	coord_t            pts_y   [MAX_POINTS];
	coord_t            pts_z   [MAX_POINTS];
	logic [GRP_W-1:0]  pts_grp [MAX_POINTS];
	int                pts_count  = 0;
	logic [NB_W-1:0]   nb_setting = NEIGHBOURS_RST;

	tally_t tallies_due [$];
	int     err_count    = 0;
	int     words_sent   = 0;
	int     stall_cycles = 0;
	bit     gaps_on      = 1'b1;

	stim_row_t directed_words [DIR_ROWS] = '{
		// empty store after reset: no votes
		'{FUNC_QUERY, 16'h0000, 16'h0000, 16'h0000, GRP_ZERO, 1'b1, 1'b1, 5'd0, 5'd0},
		'{FUNC_NOP,   16'h7fff, 16'h8000, 16'h1234, GRP_ODD,  1'b0, 1'b0, 5'd0, 5'd0},
		// the unused code must not have loaded anything
		'{FUNC_QUERY, 16'h0000, 16'h0000, 16'h0000, GRP_ZERO, 1'b1, 1'b1, 5'd0, 5'd0},
		'{FUNC_LOAD,  16'h7fff, 16'h7fff, 16'h7fff, GRP_ZERO, 1'b0, 1'b0, 5'd0, 5'd0},
		'{FUNC_LOAD,  16'h8000, 16'h8000, 16'h8000, GRP_ONE,  1'b0, 1'b0, 5'd0, 5'd0},
		'{FUNC_QUERY, 16'h8000, 16'h8000, 16'h8000, GRP_ZERO, 1'b0, 1'b0, 5'd0, 5'd0},
		'{FUNC_QUERY, 16'h7fff, 16'h7fff, 16'h7fff, GRP_ODD,  1'b0, 1'b0, 5'd0, 5'd0},
		'{FUNC_LOAD,  16'h0000, 16'h0000, 16'h0000, GRP_NONE, 1'b0, 1'b0, 5'd0, 5'd0},
		'{FUNC_LOAD,  16'h0000, 16'h0000, 16'h0000, GRP_ODD,  1'b0, 1'b0, 5'd0, 5'd0},
		'{FUNC_LOAD,  16'h0000, 16'h0000, 16'h0001, GRP_ZERO, 1'b0, 1'b0, 5'd0, 5'd0},
		'{FUNC_QUERY, 16'h0000, 16'h0000, 16'h0000, GRP_ZERO, 1'b0, 1'b0, 5'd0, 5'd0},
		// same distance as the earlier group-zero point
		'{FUNC_LOAD,  16'h0001, 16'h0000, 16'h0000, GRP_ONE,  1'b0, 1'b0, 5'd0, 5'd0},
		'{FUNC_LOAD,  16'h0000, 16'hffff, 16'h0000, GRP_ONE,  1'b0, 1'b0, 5'd0, 5'd0},
		'{FUNC_QUERY, 16'h0000, 16'h0000, 16'h0000, GRP_ONE,  1'b0, 1'b0, 5'd0, 5'd0},
		'{FUNC_QUERY, 16'h0000, 16'h0000, 16'hffff, GRP_NONE, 1'b0, 1'b0, 5'd0, 5'd0},
		'{FUNC_CLEAR, 16'hffff, 16'hffff, 16'hffff, GRP_ODD,  1'b0, 1'b0, 5'd0, 5'd0},
		// store emptied by the clear
		'{FUNC_QUERY, 16'h0000, 16'h0000, 16'h0000, GRP_ZERO, 1'b1, 1'b1, 5'd0, 5'd0},
		'{FUNC_LOAD,  16'h5555, 16'haaaa, 16'h5555, GRP_ONE,  1'b0, 1'b0, 5'd0, 5'd0},
		'{FUNC_NOP,   16'haaaa, 16'h5555, 16'haaaa, GRP_ZERO, 1'b0, 1'b0, 5'd0, 5'd0},
		'{FUNC_QUERY, 16'haaaa, 16'h5555, 16'haaaa, GRP_ZERO, 1'b0, 1'b0, 5'd0, 5'd0},
		'{FUNC_LOAD,  16'h5555, 16'haaaa, 16'h5555, GRP_ZERO, 1'b0, 1'b0, 5'd0, 5'd0},
		'{FUNC_QUERY, 16'h5555, 16'haaaa, 16'h5555, GRP_ONE,  1'b0, 1'b0, 5'd0, 5'd0}
	};

	knn_two_class_classifier_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.group      (group),
		.done       (done),
		.class_out  (class_out),
		.votes_zero (votes_zero),
		.votes_one  (votes_one),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #5 clk = ~clk;

	// Rank stored points by squared distance, earlier point first on a tie, and count votes.
	function automatic tally_t vote_nearest(input coord_t qx, input coord_t qy,
			input coord_t qz);
		longint sq_dist [MAX_POINTS];
		bit     picked  [MAX_POINTS];
		longint dx, dy, dz;
		int     k, best;
		tally_t t;
		k = int'(nb_setting);
		if (k > MAX_K)
			k = MAX_K;
		if (k > pts_count)
			k = pts_count;
		for (int i = 0; i < pts_count; i++) begin
			dx = longint'(pts_x[i]) - longint'(qx);
			dy = longint'(pts_y[i]) - longint'(qy);
			dz = longint'(pts_z[i]) - longint'(qz);
			sq_dist[i] = dx * dx + dy * dy + dz * dz;
			picked[i]  = 1'b0;
		end
		t = '0;
		for (int r = 0; r < k; r++) begin
			best = -1;
			for (int i = 0; i < pts_count; i++)
				if (!picked[i] && (best < 0 || sq_dist[i] < sq_dist[best]))
					best = i;
			picked[best] = 1'b1;
			if (pts_grp[best] == GRP_ZERO)
				t.zero = t.zero + 1'b1;
			else if (pts_grp[best] == GRP_ONE)
				t.one = t.one + 1'b1;
		end
		t.cls = (t.zero > t.one) ? 1'b0 : 1'b1;
		return t;
	endfunction

	function automatic void apply_word(input logic [FUNC_W-1:0] fn, input logic [PORT_W-1:0] x,
			input logic [PORT_W-1:0] y, input logic [PORT_W-1:0] z, input logic [GRP_W-1:0] g);
		case (fn)
			FUNC_CLEAR: pts_count = 0;
			FUNC_LOAD: begin
				// drop the load once the store is full
				if (pts_count < MAX_POINTS) begin
					pts_x[pts_count]   = coord_t'(x);
					pts_y[pts_count]   = coord_t'(y);
					pts_z[pts_count]   = coord_t'(z);
					pts_grp[pts_count] = g;
					pts_count++;
				end
			end
			FUNC_QUERY: tallies_due.insert(tallies_due.size(),
				vote_nearest(coord_t'(x), coord_t'(y), coord_t'(z)));
			default: ;
		endcase
	endfunction

	function automatic logic [PORT_W-1:0] pick_coord(input int mode,
			input logic [PORT_W-1:0] center);
		logic [PORT_W-1:0] corners [6] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff,
			16'h0001, 16'h8001};
		case (mode)
			1: return PORT_W'($urandom_range(0, 6) - 3);
			2: return corners[$urandom_range(0, 5)];
			3: return center + PORT_W'($urandom_range(0, 128)) - 16'd64;
			default: return PORT_W'($urandom);
		endcase
	endfunction

	function automatic logic [GRP_W-1:0] pick_group();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return GRP_ZERO;
		if (r < 8)
			return GRP_ONE;
		return (r == 8) ? GRP_NONE : GRP_ODD;
	endfunction

	task automatic issue_word(input logic [FUNC_W-1:0] fn, input logic [PORT_W-1:0] x,
			input logic [PORT_W-1:0] y, input logic [PORT_W-1:0] z, input logic [GRP_W-1:0] g);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		start   <= 1'b1;
		func    <= fn;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		group   <= g;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		apply_word(fn, x, y, z, g);
		if (fn != FUNC_NOP)
			words_sent++;
	endtask

	task automatic drain_results(input int extra);
		start <= 1'b0;
		@(posedge clk);
		while (tallies_due.size() != 0 || busy)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// Write the neighbour count with junk in the unused bits, then read it back.
	task automatic write_neighbours(input logic [NB_W-1:0] nb);
		logic [DATA_W-1:0] word;
		word = ($urandom() & ~DATA_W'(5'h1f)) | DATA_W'(nb);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= NB_ADDR;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		nb_setting = nb;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== DATA_W'(nb)) begin
			$error("prdata: expected %0d, got %0d", nb, prdata);
			err_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	always @(posedge clk) begin : result_check
		tally_t want;
		if (arst_n && done) begin
			if (tallies_due.size() == 0) begin
				$error("unexpected result word: class_out %0d votes_zero %0d votes_one %0d",
					class_out, votes_zero, votes_one);
				err_count++;
			end else begin
				want = tallies_due.pop_front();
				if (class_out !== want.cls) begin
					$error("class_out: expected %0d, got %0d", want.cls, class_out);
					err_count++;
				end
				if (votes_zero !== want.zero) begin
					$error("votes_zero: expected %0d, got %0d", want.zero, votes_zero);
					err_count++;
				end
				if (votes_one !== want.one) begin
					$error("votes_one: expected %0d, got %0d", want.one, votes_one);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((start && !busy) || done || (psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("knn_two_class_classifier_unit: mismatch");
			$finish;
		end
	end

	initial begin
		stim_row_t         row;
		int                mode, n_load, n_query, phase;
		logic [PORT_W-1:0] center;
		logic [NB_W-1:0]   nb_next;
		logic [NB_W-1:0]   nb_sweep [7] = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31, 5'd2, 5'd15};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = directed_words[i];
			issue_word(row.fn, row.x, row.y, row.z, row.grp);
			// the table's own value stands in for the predicted one
			if (row.known)
				tallies_due[tallies_due.size() - 1] = '{row.cls, row.v0, row.v1};
		end

		phase = 0;
		while (words_sent < ITEM_TARGET) begin
			drain_results(4);
			nb_next = (phase < 7) ? nb_sweep[phase] : NB_W'($urandom_range(0, 31));
			write_neighbours(nb_next);
			gaps_on = (words_sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
			mode    = $urandom_range(0, 3);
			center  = PORT_W'($urandom);
			if ($urandom_range(0, 3) != 0 || pts_count > 40)
				issue_word(FUNC_CLEAR, PORT_W'($urandom), PORT_W'($urandom),
					PORT_W'($urandom), GRP_W'($urandom));
			// now and then overfill the store
			n_load = (phase % 6 == 2) ? $urandom_range(60, 72) : $urandom_range(1, 20);
			for (int i = 0; i < n_load; i++)
				issue_word(FUNC_LOAD, pick_coord(mode, center), pick_coord(mode, center),
					pick_coord(mode, center), pick_group());
			n_query = $urandom_range(4, 16);
			for (int q = 0; q < n_query; q++) begin
				case ($urandom_range(0, 31))
					0, 1: issue_word(FUNC_NOP, PORT_W'($urandom), PORT_W'($urandom),
						PORT_W'($urandom), GRP_W'($urandom));
					2, 3, 4: issue_word(FUNC_LOAD, pick_coord(mode, center),
						pick_coord(mode, center), pick_coord(mode, center), pick_group());
					5: issue_word(FUNC_CLEAR, PORT_W'($urandom), PORT_W'($urandom),
						PORT_W'($urandom), GRP_W'($urandom));
					default: issue_word(FUNC_QUERY, pick_coord(mode, center),
						pick_coord(mode, center), pick_coord(mode, center), GRP_W'($urandom));
				endcase
			end
			phase++;
		end

		drain_results(SETTLE_CYCLES);
		if (err_count == 0 && tallies_due.size() == 0)
			$display("knn_two_class_classifier_unit: match");
		else
			$display("knn_two_class_classifier_unit: mismatch");
		$finish;
	end

endmodule
